FILE: sv/gbs_pkg.sv
// shared constants and types for the greedy box suppression block
`default_nettype none

package gbs_pkg;

  localparam int FIELD_BITS         = 12;
  localparam int SLOT_BITS          = 6;
  localparam int THRESH_BITS        = 9;
  localparam int SCALE_SHIFT        = 8;
  localparam int MAX_KEPT_DEFAULT   = 64;
  localparam int COORD_BITS_DEFAULT = 12;

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 9'd128;

  typedef struct packed {
    logic busy;
    logic hit;
    logic over;
  } gbs_iou_st_t;

endpackage

`default_nettype wire

FILE: sv/greedy_box_suppression_top.sv
// top level: greedy box suppression sequencer around the kept-box table
//
// boxes arrive on the box channel (box_valid / box_stall) in descending score
// order; each item carries start_set and the box geometry. one result item
// per box leaves on the result channel (result_valid / result_stall) with
// keep, kept_slot and table_full. overlap_threshold is written through the
// thresh channel (thresh_valid / thresh_ready, always ready); the user must
// write it only while idle, the block itself does not enforce this. a box
// is checked against every kept box read from the table ram, one entry per
// cycle, through a five stage overlap pipeline. the result of an item is
// registered once the scan of all kept entries through the single ram read
// port and the pipeline have drained; a new box is taken once the previous
// result is in the output register. start_set empties the table first.
// a stalled result holds in the output register; the next box is still
// accepted and judged, but its result waits until the register frees.
// reset empties the table, sets the threshold to 128 and clears all valids.
`default_nettype none

module greedy_box_suppression_top #(
  parameter int MAX_KEPT   = gbs_pkg::MAX_KEPT_DEFAULT,
  parameter int COORD_BITS = gbs_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            box_valid,
  output logic                                 box_stall,
  input  wire logic                            start_set,
  input  wire logic [gbs_pkg::FIELD_BITS-1:0]  box_x,
  input  wire logic [gbs_pkg::FIELD_BITS-1:0]  box_y,
  input  wire logic [gbs_pkg::FIELD_BITS-1:0]  box_width,
  input  wire logic [gbs_pkg::FIELD_BITS-1:0]  box_height,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output logic                                 keep,
  output logic      [gbs_pkg::SLOT_BITS-1:0]   kept_slot,
  output logic                                 table_full,
  input  wire logic                            thresh_valid,
  output logic                                 thresh_ready,
  input  wire logic [gbs_pkg::THRESH_BITS-1:0] overlap_threshold
);

  import gbs_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CW = $clog2(MAX_KEPT + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  logic [1:0]             state;
  logic [THRESH_BITS-1:0] thr;
  logic [CW-1:0]          count;
  logic [CW-1:0]          idx;
  logic                   rd_pending;
  logic                   suppressed;
  logic [4*C-1:0]         cand;
  logic [2*C-1:0]         cand_area;
  logic [4*C-1:0]         rd_data;
  logic [C-1:0]           mw, mh;
  logic                   rd_en, wr_en, out_free, room, box_take;
  gbs_iou_st_t            st;

  assign mw        = C'(box_width);
  assign mh        = C'(box_height);
  assign box_stall = (state != ST_IDLE) | rst;
  assign box_take  = box_valid & ~box_stall;
  assign rd_en     = (state == ST_SCAN) && (idx != count);
  assign out_free  = ~result_valid | ~result_stall;
  assign room      = count < CW'(MAX_KEPT);
  assign wr_en     = (state == ST_DECIDE) && out_free && ~suppressed && room;
  assign thresh_ready = 1'b1;

  gbs_ram #(
    .WIDTH (4 * C),
    .DEPTH (MAX_KEPT)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (cand),
    .rd_en   (rd_en),
    .rd_addr (idx[AW-1:0]),
    .rd_data (rd_data)
  );

  gbs_iou #(
    .COORD_BITS (C)
  ) u_iou (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_pending),
    .thresh    (thr),
    .cand      (cand),
    .cand_area (cand_area),
    .kept      (rd_data),
    .st        (st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      thr          <= THRESH_RESET;
      count        <= '0;
      idx          <= '0;
      rd_pending   <= 1'b0;
      suppressed   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (thresh_valid && thresh_ready) begin
        thr <= overlap_threshold;
      end
      rd_pending <= rd_en;
      if (result_valid && !result_stall && state != ST_DECIDE) begin
        result_valid <= 1'b0;
      end
      if (st.hit && st.over) begin
        suppressed <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (box_take) begin
            if (start_set) begin
              count <= '0;
            end
            idx        <= '0;
            suppressed <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            idx <= idx + CW'(1);
          end else if (!rd_pending && !st.busy) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (out_free) begin
            result_valid <= 1'b1;
            if (wr_en) begin
              count <= count + CW'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (box_take) begin
      cand      <= {C'(box_x), C'(box_y), mw, mh};
      cand_area <= (2 * C)'(mw) * (2 * C)'(mh);
    end
    if (state == ST_DECIDE && out_free) begin
      keep       <= ~suppressed;
      kept_slot  <= wr_en ? SLOT_BITS'(count) : '0;
      table_full <= ~suppressed & ~room;
    end
  end

endmodule

`default_nettype wire

FILE: sv/gbs_ram.sv
// generic single-write, single-read synchronous ram with registered read
`default_nettype none

module gbs_ram #(
  parameter int WIDTH     = 48,
  parameter int DEPTH     = 64,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]     wr_data,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output logic      [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/gbs_iou.sv
// pipelined overlap test of the candidate against one kept box per cycle
`default_nettype none

module gbs_iou #(
  parameter int COORD_BITS = gbs_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic [gbs_pkg::THRESH_BITS-1:0] thresh,
  input  wire logic [4*COORD_BITS-1:0]        cand,
  input  wire logic [2*COORD_BITS-1:0]        cand_area,
  input  wire logic [4*COORD_BITS-1:0]        kept,
  output gbs_pkg::gbs_iou_st_t                st
);

  import gbs_pkg::*;

  localparam int C = COORD_BITS;
  localparam int A = 2 * C;
  localparam int U = A + 1;
  localparam int P = U + THRESH_BITS;
  localparam int L = A + SCALE_SHIFT;

  logic [C-1:0] cx, cy, cw, ch, kx, ky, kw, kh;
  logic [C:0]   x1, y1, cx1, cy1, kx1, ky1;
  logic [C-1:0] x0, y0, iw, ih;

  logic         v1, v2, v3, v4, v5;
  logic [C-1:0] iw1, ih1, kw1, kh1;
  logic [A-1:0] inter2, karea2;
  logic [A-1:0] inter3;
  logic [U-1:0] union3;
  logic [P-1:0] prod4;
  logic [L-1:0] lhs4;
  logic         over5;

  assign cx = cand[4*C-1:3*C];
  assign cy = cand[3*C-1:2*C];
  assign cw = cand[2*C-1:C];
  assign ch = cand[C-1:0];
  assign kx = kept[4*C-1:3*C];
  assign ky = kept[3*C-1:2*C];
  assign kw = kept[2*C-1:C];
  assign kh = kept[C-1:0];

  always_comb begin
    cx1 = {1'b0, cx} + {1'b0, cw};
    cy1 = {1'b0, cy} + {1'b0, ch};
    kx1 = {1'b0, kx} + {1'b0, kw};
    ky1 = {1'b0, ky} + {1'b0, kh};
    x0  = (cx > kx) ? cx : kx;
    y0  = (cy > ky) ? cy : ky;
    x1  = (cx1 < kx1) ? cx1 : kx1;
    y1  = (cy1 < ky1) ? cy1 : ky1;
    iw  = (x1 > {1'b0, x0}) ? C'(x1 - {1'b0, x0}) : '0;
    ih  = (y1 > {1'b0, y0}) ? C'(y1 - {1'b0, y0}) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
    iw1    <= iw;
    ih1    <= ih;
    kw1    <= kw;
    kh1    <= kh;
    inter2 <= A'(iw1) * A'(ih1);
    karea2 <= A'(kw1) * A'(kh1);
    inter3 <= inter2;
    union3 <= U'(cand_area) + U'(karea2) - U'(inter2);
    prod4  <= P'(thresh) * P'(union3);
    lhs4   <= L'(inter3) << SCALE_SHIFT;
    over5  <= P'(lhs4) > prod4;
  end

  assign st.busy = v1 | v2 | v3 | v4 | v5;
  assign st.hit  = v5;
  assign st.over = over5;

endmodule

`default_nettype wire

FILE: sv/gbs_checker.sv
// port-level checker for the greedy box suppression top, bound to it
`default_nettype none

module gbs_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          box_valid,
  input wire logic                          box_stall,
  input wire logic                          result_valid,
  input wire logic                          result_stall,
  input wire logic                          keep,
  input wire logic [gbs_pkg::SLOT_BITS-1:0] kept_slot,
  input wire logic                          table_full
);

  // stalled result item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(keep)
      && $stable(kept_slot) && $stable(table_full))
    else $error("stalled result changed");

  a_full_kept: assert property (@(posedge clk) disable iff (rst)
    result_valid && table_full |-> keep && kept_slot == '0)
    else $error("table_full without a kept box");

  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && !keep |-> kept_slot == '0 && !table_full)
    else $error("suppressed box reports a slot");

  // one box at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    box_valid && !box_stall |=> box_stall)
    else $error("box taken while busy");

endmodule

bind greedy_box_suppression_top gbs_checker u_gbs_checker (.*);

`default_nettype wire

FILE: tb/box_suppression_checker.sv
// checker: predicts the verdict for every box item and compares result items
module box_suppression_checker #(
  parameter int MAX_KEPT = gbs_pkg::MAX_KEPT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            box_valid,
  input  logic                            box_stall,
  input  logic                            start_set,
  input  logic [gbs_pkg::FIELD_BITS-1:0]  box_x,
  input  logic [gbs_pkg::FIELD_BITS-1:0]  box_y,
  input  logic [gbs_pkg::FIELD_BITS-1:0]  box_width,
  input  logic [gbs_pkg::FIELD_BITS-1:0]  box_height,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  logic                            keep,
  input  logic [gbs_pkg::SLOT_BITS-1:0]   kept_slot,
  input  logic                            table_full,
  input  logic                            thresh_valid,
  input  logic                            thresh_ready,
  input  logic [gbs_pkg::THRESH_BITS-1:0] overlap_threshold,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = gbs_pkg::FIELD_BITS;
  localparam int SB = gbs_pkg::SLOT_BITS;

  typedef struct packed {
    logic          kept;
    logic [SB-1:0] slot;
    logic          full;
  } verdict_t;

  logic [FB-1:0]                   tbl_x [MAX_KEPT];
  logic [FB-1:0]                   tbl_y [MAX_KEPT];
  logic [FB-1:0]                   tbl_w [MAX_KEPT];
  logic [FB-1:0]                   tbl_h [MAX_KEPT];
  int                              kept_n;
  logic [gbs_pkg::THRESH_BITS-1:0] iou_limit;
  verdict_t                        verdicts_due[$];

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic verdict_t judge_box(logic clear, logic [FB-1:0] x, logic [FB-1:0] y,
                                         logic [FB-1:0] w, logic [FB-1:0] h);
    logic [FB:0] c_r, c_b, k_r, k_b, lo_x, lo_y, hi_x, hi_y;
    logic [63:0] cand_area, inter, uni;
    logic        survive;
    verdict_t    v;
    if (clear) begin
      kept_n = 0;
    end
    cand_area = 64'(w) * 64'(h);
    survive = 1'b1;
    c_r = {1'b0, x} + {1'b0, w};
    c_b = {1'b0, y} + {1'b0, h};
    for (int i = 0; i < kept_n; i++) begin
      k_r = {1'b0, tbl_x[i]} + {1'b0, tbl_w[i]};
      k_b = {1'b0, tbl_y[i]} + {1'b0, tbl_h[i]};
      lo_x = (x > tbl_x[i]) ? {1'b0, x} : {1'b0, tbl_x[i]};
      lo_y = (y > tbl_y[i]) ? {1'b0, y} : {1'b0, tbl_y[i]};
      hi_x = (c_r < k_r) ? c_r : k_r;
      hi_y = (c_b < k_b) ? c_b : k_b;
      if (hi_x <= lo_x || hi_y <= lo_y) begin
        inter = '0;
      end else begin
        inter = 64'(hi_x - lo_x) * 64'(hi_y - lo_y);
      end
      uni = cand_area + 64'(tbl_w[i]) * 64'(tbl_h[i]) - inter;
      if ((inter << gbs_pkg::SCALE_SHIFT) > 64'(iou_limit) * uni) begin
        survive = 1'b0;
      end
    end
    v = '0;
    v.kept = survive;
    if (survive) begin
      if (kept_n < MAX_KEPT) begin
        tbl_x[kept_n] = x;
        tbl_y[kept_n] = y;
        tbl_w[kept_n] = w;
        tbl_h[kept_n] = h;
        v.slot = SB'(kept_n);
        kept_n++;
      end else begin
        v.full = 1'b1;
      end
    end
    return v;
  endfunction

  always @(posedge clk) begin : watch
    verdict_t want;
    if (rst) begin
      fail_count = 0;
      kept_n = 0;
      iou_limit = gbs_pkg::THRESH_RESET;
      verdicts_due.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch("result item with no box pending", 0, 0);
        end else begin
          want = verdicts_due.pop_front();
          if (keep !== want.kept) begin
            report_mismatch("keep", 32'(keep), 32'(want.kept));
          end
          if (kept_slot !== want.slot) begin
            report_mismatch("kept_slot", 32'(kept_slot), 32'(want.slot));
          end
          if (table_full !== want.full) begin
            report_mismatch("table_full", 32'(table_full), 32'(want.full));
          end
        end
      end
      if (box_valid && !box_stall) begin
        verdicts_due = {verdicts_due,
                        judge_box(start_set, box_x, box_y, box_width, box_height)};
      end
      if (thresh_valid && thresh_ready) begin
        iou_limit = overlap_threshold;
      end
    end
    pending = verdicts_due.size();
  end

endmodule

FILE: tb/testbench.sv
// testbench top: drives boxes and thresholds into the suppression block and gives the verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB          = gbs_pkg::FIELD_BITS;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 166;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            box_valid = 1'b0;
  logic                            box_stall;
  logic                            start_set = 1'b0;
  logic [FB-1:0]                   box_x = '0;
  logic [FB-1:0]                   box_y = '0;
  logic [FB-1:0]                   box_width = '0;
  logic [FB-1:0]                   box_height = '0;
  logic                            result_valid;
  logic                            result_stall = 1'b0;
  logic                            keep;
  logic [gbs_pkg::SLOT_BITS-1:0]   kept_slot;
  logic                            table_full;
  logic                            thresh_valid = 1'b0;
  logic                            thresh_ready;
  logic [gbs_pkg::THRESH_BITS-1:0] overlap_threshold = '0;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  greedy_box_suppression_top u_top (
    .clk               (clk),
    .rst               (rst),
    .box_valid         (box_valid),
    .box_stall         (box_stall),
    .start_set         (start_set),
    .box_x             (box_x),
    .box_y             (box_y),
    .box_width         (box_width),
    .box_height        (box_height),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .keep              (keep),
    .kept_slot         (kept_slot),
    .table_full        (table_full),
    .thresh_valid      (thresh_valid),
    .thresh_ready      (thresh_ready),
    .overlap_threshold (overlap_threshold)
  );

  box_suppression_checker u_check (
    .clk               (clk),
    .rst               (rst),
    .box_valid         (box_valid),
    .box_stall         (box_stall),
    .start_set         (start_set),
    .box_x             (box_x),
    .box_y             (box_y),
    .box_width         (box_width),
    .box_height        (box_height),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .keep              (keep),
    .kept_slot         (kept_slot),
    .table_full        (table_full),
    .thresh_valid      (thresh_valid),
    .thresh_ready      (thresh_ready),
    .overlap_threshold (overlap_threshold),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && ((box_valid && !box_stall) || (result_valid && !result_stall) ||
                 (thresh_valid && thresh_ready))) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_box(logic first, int x, int y, int w, int h);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      box_valid <= 1'b0;
      @(negedge clk);
    end
    box_valid  <= 1'b1;
    start_set  <= first;
    box_x      <= FB'(x);
    box_y      <= FB'(y);
    box_width  <= FB'(w);
    box_height <= FB'(h);
    @(posedge clk);
    while (box_stall) begin
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    box_valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_threshold(int value);
    wait_drained();
    @(negedge clk);
    thresh_valid      <= 1'b1;
    overlap_threshold <= gbs_pkg::THRESH_BITS'(value);
    @(posedge clk);
    while (!thresh_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    thresh_valid <= 1'b0;
  endtask

  task automatic run_random(int n);
    int sent, kind, len, ax, ay, bw, bh, base, spot, w, h, r;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(99);
      if (kind < 10) begin
        // noise: any field value, start flag anywhere
        send_box(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom);
        sent++;
      end else if (kind < 18) begin
        // long set of disjoint boxes on a 9x9 grid, runs past a full table
        len = $urandom_range(66, 72);
        base = $urandom_range(80);
        for (int k = 0; k < len; k++) begin
          spot = (base + k * 7) % 81;
          send_box(k == 0, (spot % 9) * 450 + $urandom_range(100),
                   (spot / 9) * 450 + $urandom_range(100),
                   $urandom_range(1, 340), $urandom_range(1, 340));
          sent++;
        end
      end else begin
        // cluster of overlapping boxes around one anchor
        len = $urandom_range(3, 20);
        ax = $urandom_range(4000);
        ay = $urandom_range(4000);
        bw = $urandom_range(400);
        bh = $urandom_range(400);
        for (int k = 0; k < len; k++) begin
          r = $urandom_range(99);
          w = bw + $urandom_range(40) - 20;
          h = bh + $urandom_range(40) - 20;
          if (r < 5) begin
            w = 0;
          end else if (r < 10) begin
            h = 0;
          end else if (r < 14) begin
            w = $urandom_range(1000, 4095);
            h = $urandom_range(1000, 4095);
          end
          if (w < 0) begin
            w = 0;
          end
          if (h < 0) begin
            h = 0;
          end
          send_box(k == 0, ax + $urandom_range(64) - 32, ay + $urandom_range(64) - 32, w, h);
          sent++;
        end
      end
    end
  endtask

  initial begin
    int limit;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 33;
    recv_idle_pct = 61;

    // zero area boxes and zero union
    send_box(1, 0, 0, 0, 0);
    send_box(0, 0, 0, 0, 0);
    send_box(0, 0, 0, 0, 4095);
    // identical, partial and touching overlap
    send_box(1, 0, 0, 10, 10);
    send_box(0, 0, 0, 10, 10);
    send_box(0, 5, 0, 10, 10);
    send_box(0, 10, 0, 10, 10);
    // largest coordinates, edges past the field range
    send_box(0, 4095, 4095, 4095, 4095);
    send_box(0, 4095, 4095, 4095, 4095);
    send_box(0, 0, 0, 4095, 4095);
    // ratio exactly at the threshold
    send_box(1, 0, 0, 20, 10);
    send_box(0, 0, 0, 10, 10);
    // overlap beyond the right edge, no wrap
    send_box(1, 4000, 0, 200, 10);
    send_box(0, 4090, 0, 100, 10);
    send_box(0, 4050, 0, 200, 10);
    // start flag clears the table
    send_box(1, 2048, 2048, 2048, 2048);
    send_box(1, 2048, 2048, 2048, 2048);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: limit = 0;
        1: limit = 256;
        2: limit = 511;
        3: limit = 1;
        4: limit = 200;
        5: limit = $urandom_range(511);
        6: limit = 255;
        default: limit = 128;
      endcase
      write_threshold(limit);
      @(posedge clk);
      if (p < 3) begin
        send_idle_pct = 33;
        recv_idle_pct = 61;
      end else if (p < 6) begin
        send_idle_pct = 61;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 1) begin
        run_random(PHASE_ITEMS / 2);
        wait_drained();
        run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        run_random(PHASE_ITEMS);
      end
    end

    wait_drained();
    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/gbs_pkg.sv
sv/gbs_ram.sv
sv/gbs_iou.sv
sv/greedy_box_suppression_top.sv
sv/gbs_checker.sv
tb/box_suppression_checker.sv
tb/testbench.sv
